// ----- hdl/hacd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacd_pkg: shared types and constants of the hit accumulator digitizer
// Holds the transfer payload types, the controller state encoding, the
// command and status groups between controller and datapath, and the fixed
// constants of the energy-to-duration mapping.
// ----------------------------------------------------------------------------
package hacd_pkg;

  // Input item: a hit deposit or an end-of-event marker.
  typedef struct packed {
    logic               func;
    logic [7:0]         module_copy;
    logic signed [19:0] energy_kev;
    logic [19:0]        hit_time;
  } hacd_in_t;

  // Result item: one digit, or the empty end marker.
  typedef struct packed {
    logic        digit_valid;
    logic [5:0]  digit_module;
    logic [12:0] signal_duration;
    logic [19:0] earliest_time;
    logic [6:0]  fired_count;
    logic        last;
  } hacd_out_t;

  // Item codes.
  localparam logic FUNC_HIT = 1'b0;
  localparam logic FUNC_END = 1'b1;

  // Configuration port.
  localparam int          ADDR_W        = 3;
  localparam logic        REG_THRESHOLD = 1'b0;
  localparam logic [19:0] THRESHOLD_RST = 20'd400;

  // Accumulator widths.
  localparam int SUM_W  = 24;
  localparam int TIME_W = 20;
  localparam int WORD_W = SUM_W + TIME_W;

  // Energy-to-duration mapping: 300 keV .. 50 MeV onto 6 .. 18 ns (1/256 ns).
  localparam logic [23:0] E_LOW  = 24'd300;
  localparam logic [23:0] E_HIGH = 24'd50000;
  localparam logic [15:0] E_LOW16 = 16'd300;
  localparam logic [12:0] D_LOW  = 13'd1536;
  localparam logic [12:0] D_HIGH = 13'd4608;

  // The rounded quotient ((sum - 300) * 3072 + 24850) / 49700 equals
  // ((sum - 300) * 1536 + 12425) / 24850. The numerator stays below 2^27,
  // so a reciprocal rounded up with a 42-bit shift gives the exact floor.
  localparam int          NUM_W         = 27;
  localparam int          QUO_W         = 12;
  localparam int          DUR_SHIFT     = 42;
  localparam logic [26:0] DUR_BIAS      = 27'd12425;
  localparam logic [63:0] DUR_DIV       = 64'd24850;
  localparam logic [63:0] DUR_RECIP_ALL = ((64'd1 << DUR_SHIFT) + DUR_DIV - 64'd1) / DUR_DIV;
  localparam logic [27:0] DUR_RECIP     = DUR_RECIP_ALL[27:0];
  localparam int          PROD_W        = NUM_W + 28;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_MUL,
    ST_SCAN_PUT,
    ST_FLUSH
  } hacd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_hit;
    logic hit_read;
    logic hit_write;
    logic scan_init;
    logic scan_read;
    logic scan_eval;
    logic scan_mul;
    logic scan_put;
    logic scan_next;
    logic flush;
  } hacd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic hit_ok;
    logic fire;
    logic scan_last;
    logic pend_valid;
    logic out_free;
  } hacd_status_t;

endpackage

// ----- hdl/module_hit_accumulator_digitizer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_hit_accumulator_digitizer_unit: per-module hit summing and digitizing
// Accumulates hit energies and earliest times per detector module over an
// event and emits one digit per module at or above threshold at the end of event.
// ----------------------------------------------------------------------------
// A hit item passes through the transfer, a memory read and a memory write,
// set by the read-modify-write through the single-port sum and time memory;
// a hit whose copy number is out of range is taken at the transfer and
// dropped. An end-of-event item takes a read and a check for each module,
// a multiply and a put besides for each module that fires, and a final
// flush, and it waits while a stalled result side keeps the result register
// full. Each digit is held until the next one is found, so the last flag is
// known when it leaves. No new item is taken until the current one is
// finished. The threshold register sits at byte address 0.
module module_hit_accumulator_digitizer_unit #(
  parameter int NUM_MODULES = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  hacd_pkg::hacd_in_t             item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output hacd_pkg::hacd_out_t            result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hacd_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [19:0]            threshold;
  hacd_pkg::hacd_cmd_t    cmd;
  hacd_pkg::hacd_status_t status;
  logic                   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= hacd_pkg::THRESHOLD_RST;
    end else if (psel && penable && pwrite && (reg_sel == hacd_pkg::REG_THRESHOLD)) begin
      threshold <= pwdata[19:0];
    end
  end

  // Register read back.
  always_comb begin
    if (reg_sel == hacd_pkg::REG_THRESHOLD) begin
      prdata = {12'd0, threshold};
    end else begin
      prdata = '0;
    end
  end

  hacd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  hacd_datapath #(
    .NUM_MODULES (NUM_MODULES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .threshold    (threshold),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- hdl/hacd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacd_ctrl: sequencer of the hit accumulator digitizer
// Steps the datapath through the read-modify-write of a hit and through the
// module scan of an end-of-event item.
// ----------------------------------------------------------------------------
module hacd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  hacd_pkg::hacd_status_t status,
  output hacd_pkg::hacd_cmd_t    cmd
);

  hacd_pkg::hacd_state_t state;
  hacd_pkg::hacd_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hacd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      hacd_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (status.is_end) begin
            cmd.scan_init = 1'b1;
            state_next    = hacd_pkg::ST_SCAN_RD;
          end else if (status.hit_ok) begin
            cmd.take_hit = 1'b1;
            state_next   = hacd_pkg::ST_HIT_RD;
          end
        end
      end
      hacd_pkg::ST_HIT_RD: begin
        cmd.hit_read = 1'b1;
        state_next   = hacd_pkg::ST_HIT_WR;
      end
      hacd_pkg::ST_HIT_WR: begin
        cmd.hit_write = 1'b1;
        state_next    = hacd_pkg::ST_IDLE;
      end
      hacd_pkg::ST_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = hacd_pkg::ST_SCAN_CHK;
      end
      hacd_pkg::ST_SCAN_CHK: begin
        cmd.scan_eval = 1'b1;
        if (status.fire) begin
          state_next = hacd_pkg::ST_SCAN_MUL;
        end else if (status.scan_last) begin
          state_next = hacd_pkg::ST_FLUSH;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = hacd_pkg::ST_SCAN_RD;
        end
      end
      hacd_pkg::ST_SCAN_MUL: begin
        cmd.scan_mul = 1'b1;
        state_next   = hacd_pkg::ST_SCAN_PUT;
      end
      hacd_pkg::ST_SCAN_PUT: begin
        // A held digit can only move on once the result register is free.
        if (!status.pend_valid || status.out_free) begin
          cmd.scan_put = 1'b1;
          if (status.scan_last) begin
            state_next = hacd_pkg::ST_FLUSH;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = hacd_pkg::ST_SCAN_RD;
          end
        end
      end
      hacd_pkg::ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = hacd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hacd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/hacd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacd_datapath: storage and arithmetic of the hit accumulator digitizer
// Holds the per-module hit flags and the sum/minimum-time memory, the
// saturating accumulate, the threshold test, the reciprocal duration unit,
// the held digit that waits for its successor and the result register.
// ----------------------------------------------------------------------------
module hacd_datapath #(
  parameter int NUM_MODULES = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hacd_pkg::hacd_in_t     item,
  input  logic [19:0]            threshold,
  input  hacd_pkg::hacd_cmd_t    cmd,
  output hacd_pkg::hacd_status_t status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output hacd_pkg::hacd_out_t    result
);

  localparam int IDX_W = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_MODULES - 1);
  localparam logic [7:0]       COPY_MAX = 8'(NUM_MODULES);

  // Hit fields latched at the transfer.
  logic [IDX_W-1:0]         hit_idx;
  logic signed [19:0]       hit_energy;
  logic [19:0]              hit_time;

  // Module storage.
  logic [NUM_MODULES-1:0]   flags;
  logic [hacd_pkg::WORD_W-1:0] mem [NUM_MODULES];
  logic [hacd_pkg::WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]         rd_addr;

  // Scan and duration pipeline.
  logic [IDX_W-1:0]         scan_idx;
  logic [hacd_pkg::NUM_W-1:0] eval_n;
  logic                     eval_low;
  logic                     eval_high;
  logic [hacd_pkg::QUO_W-1:0] dur_q;
  logic [6:0]               fired;
  hacd_pkg::hacd_out_t      pend;
  logic                     pend_valid;

  logic [7:0]               copy_less;
  logic signed [23:0]       old_sum;
  logic [19:0]              old_time;
  logic signed [24:0]       wide_sum;
  logic signed [23:0]       sum_next;
  logic [19:0]              time_next;
  logic [15:0]              diff;
  logic [hacd_pkg::PROD_W-1:0] prod;
  logic [12:0]              duration;
  logic                     out_free;
  hacd_pkg::hacd_out_t      digit;
  hacd_pkg::hacd_out_t      tail;

  assign copy_less = item.module_copy - 8'd1;
  assign old_sum   = rd_data[hacd_pkg::WORD_W-1:hacd_pkg::TIME_W];
  assign old_time  = rd_data[hacd_pkg::TIME_W-1:0];
  assign out_free  = !result_valid || !result_stall;

  // Status toward the controller.
  always_comb begin
    status.is_end     = (item.func == hacd_pkg::FUNC_END);
    status.hit_ok     = (item.module_copy != 8'd0) && (item.module_copy <= COPY_MAX);
    status.fire       = flags[scan_idx] && !old_sum[23] &&
                        (old_sum >= $signed({4'd0, threshold}));
    status.scan_last  = (scan_idx == IDX_LAST);
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  // Latch a hit.
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      hit_idx    <= copy_less[IDX_W-1:0];
      hit_energy <= item.energy_kev;
      hit_time   <= item.hit_time;
    end
  end

  // Saturating accumulate and minimum time; a first hit replaces both.
  always_comb begin
    wide_sum = {old_sum[23], old_sum} + {{5{hit_energy[19]}}, hit_energy};
    if (wide_sum[24] != wide_sum[23]) begin
      sum_next = wide_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      sum_next = wide_sum[23:0];
    end
    time_next = (hit_time < old_time) ? hit_time : old_time;
    if (!flags[hit_idx]) begin
      sum_next  = {{4{hit_energy[19]}}, hit_energy};
      time_next = hit_time;
    end
  end

  // Sum and minimum-time memory, one read or one write a cycle.
  assign rd_addr = cmd.hit_read ? hit_idx : scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.hit_write) begin
      mem[hit_idx] <= {sum_next, time_next};
    end
    if (cmd.hit_read || cmd.scan_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hit flags: set by a hit, cleared at the end of the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.flush) begin
      flags <= '0;
    end else if (cmd.hit_write) begin
      flags[hit_idx] <= 1'b1;
    end
  end

  // Scan index.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_next) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // Clamp classes and the division numerator of the duration.
  assign diff = old_sum[15:0] - hacd_pkg::E_LOW16;

  always_ff @(posedge clk) begin
    if (cmd.scan_eval) begin
      eval_low  <= (old_sum <= $signed(hacd_pkg::E_LOW));
      eval_high <= (old_sum >= $signed(hacd_pkg::E_HIGH));
      eval_n    <= {1'b0, diff, 10'd0} + {2'b0, diff, 9'd0} + hacd_pkg::DUR_BIAS;
    end
  end

  // Division by a constant through the reciprocal product.
  assign prod = eval_n * hacd_pkg::DUR_RECIP;

  always_ff @(posedge clk) begin
    if (cmd.scan_mul) begin
      dur_q <= prod[hacd_pkg::DUR_SHIFT +: hacd_pkg::QUO_W];
    end
  end

  always_comb begin
    priority if (eval_low) begin
      duration = hacd_pkg::D_LOW;
    end else if (eval_high) begin
      duration = hacd_pkg::D_HIGH;
    end else begin
      duration = hacd_pkg::D_LOW + {1'b0, dur_q};
    end
    digit.digit_valid     = 1'b1;
    digit.digit_module    = 6'(scan_idx);
    digit.signal_duration = duration;
    digit.earliest_time   = old_time;
    digit.fired_count     = fired + 7'd1;
    digit.last            = 1'b0;
  end

  // Final item of the scan: the held digit, or the empty marker, flagged last.
  always_comb begin
    tail      = pend_valid ? pend : '0;
    tail.last = 1'b1;
  end

  // Held digit: released once the next one is found or the scan ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      fired      <= '0;
    end else begin
      if (cmd.scan_init || cmd.flush) begin
        pend_valid <= 1'b0;
        fired      <= '0;
      end else if (cmd.scan_put) begin
        pend_valid <= 1'b1;
        fired      <= fired + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_put) begin
      pend <= digit;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if ((cmd.scan_put && pend_valid) || cmd.flush) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_put && pend_valid) begin
      result <= pend;
    end else if (cmd.flush) begin
      result <= tail;
    end
  end

  // The end of the scan leaves no module flagged.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (flags == '0))
    else $error("hit flags survive the end of the scan");

  // A held digit is never pushed into an occupied result register.
  a_put_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_put && pend_valid) |-> out_free)
    else $error("digit released into a full result register");

  // Every digit carries a duration inside the mapped range.
  a_dur_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.digit_valid) |->
      (result.signal_duration >= hacd_pkg::D_LOW) &&
      (result.signal_duration <= hacd_pkg::D_HIGH))
    else $error("signal duration out of range");

  // The empty marker is the last item and counts no digit.
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.digit_valid) |->
      (result.last && (result.fired_count == 7'd0)))
    else $error("malformed empty end marker");

endmodule

// ----- test/module_hit_accumulator_digitizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_hit_accumulator_digitizer_unit_tb: self-checking bench of the digitizer
// Drives hit and end-of-event items through the valid/stall item channel with
// random gaps, stalls the result channel at random, and compares every result
// with a per-module digitizer model kept inside the bench. The threshold
// register is written and read back over the APB port between phases.
// ----------------------------------------------------------------------------
module module_hit_accumulator_digitizer_unit_tb;

  localparam int NUM_MODULES   = 40;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 50;
  localparam int LIMIT_NS      = 4_000_000;

  // Duration mapping of the model: 300 keV .. 50 MeV onto 6 .. 18 ns.
  localparam int  DUR_E_LOW  = 300;
  localparam int  DUR_E_HIGH = 50000;
  localparam int  DUR_LOW    = 1536;
  localparam int  DUR_HIGH   = 4608;
  localparam int  ACC_MAX    = 8388607;
  localparam int  ACC_MIN    = -8388608;
  localparam logic [hacd_pkg::ADDR_W-1:0] THRESHOLD_ADDR = {hacd_pkg::REG_THRESHOLD, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  hacd_pkg::hacd_in_t  item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  hacd_pkg::hacd_out_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [hacd_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  module_hit_accumulator_digitizer_unit #(
    .NUM_MODULES(NUM_MODULES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Digitizer model state and bench bookkeeping.
  logic        hit_flag_m [NUM_MODULES];
  int          energy_sum_m [NUM_MODULES];
  logic [19:0] min_time_m [NUM_MODULES];
  logic [19:0] threshold_m = hacd_pkg::THRESHOLD_RST;

  hacd_pkg::hacd_in_t  stim_q [$];
  hacd_pkg::hacd_out_t digit_q [$];
  int          items_total = 0;
  int          items_taken = 0;
  int          live_items = 0;
  int          mismatches = 0;
  int          reg_errors = 0;
  bit          calm = 1'b0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic [19:0] last_time = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("module_hit_accumulator_digitizer_unit_tb failed");
    $finish;
  end

  // Duration in 1/256 ns for a module sum, rounded to nearest, halves up.
  function automatic logic [12:0] duration_for(input int sum);
    longint num;
    if (sum <= DUR_E_LOW) return 13'(DUR_LOW);
    if (sum >= DUR_E_HIGH) return 13'(DUR_HIGH);
    num = (longint'(sum) - DUR_E_LOW) * (DUR_HIGH - DUR_LOW) + (DUR_E_HIGH - DUR_E_LOW) / 2;
    num = num / (DUR_E_HIGH - DUR_E_LOW);
    return 13'(DUR_LOW + num);
  endfunction

  // Adds one hit to its module; copies outside 1..NUM_MODULES are dropped.
  task automatic accumulate_hit(input hacd_pkg::hacd_in_t it);
    int idx;
    int s;
    if (it.module_copy != 0 && it.module_copy <= NUM_MODULES) begin
      idx = int'(it.module_copy) - 1;
      if (!hit_flag_m[idx]) begin
        hit_flag_m[idx] = 1'b1;
        energy_sum_m[idx] = int'(it.energy_kev);
        min_time_m[idx] = it.hit_time;
      end else begin
        s = energy_sum_m[idx] + int'(it.energy_kev);
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        energy_sum_m[idx] = s;
        if (it.hit_time < min_time_m[idx]) min_time_m[idx] = it.hit_time;
      end
    end
  endtask

  // End of event: queue one digit per module at or above threshold, or the
  // empty marker, then clear every module.
  task automatic scan_event();
    hacd_pkg::hacd_out_t d;
    int fired;
    fired = 0;
    for (int m = 0; m < NUM_MODULES; m++) begin
      if (hit_flag_m[m] && energy_sum_m[m] >= 0 && energy_sum_m[m] >= int'(threshold_m)) begin
        fired++;
        d = '0;
        d.digit_valid = 1'b1;
        d.digit_module = 6'(m);
        d.signal_duration = duration_for(energy_sum_m[m]);
        d.earliest_time = min_time_m[m];
        d.fired_count = 7'(fired);
        digit_q.push_back(d);
      end
      hit_flag_m[m] = 1'b0;
    end
    if (fired == 0) begin
      d = '0;
      d.last = 1'b1;
    end else begin
      d = digit_q.pop_back();
      d.last = 1'b1;
    end
    digit_q.push_back(d);
  endtask

  // Item driver: one item at a time from the pending queue, random gaps.
  always @(negedge clk) begin
    logic v;
    v = item_valid;
    if (rst) begin
      v = 1'b0;
      gap_left = 0;
    end else begin
      if (v && in_taken) begin
        v = 1'b0;
        gap_left = calm ? 0 : $urandom_range(0, 16);
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          item <= stim_q.pop_front();
          v = 1'b1;
        end
      end
    end
    item_valid <= v;
  end

  // Result side: after each transfer, stall the next result a random while.
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else begin
      if (out_taken) stall_left = calm ? 0 : $urandom_range(0, 16);
      result_stall <= (stall_left > 0);
      if (stall_left > 0 && result_valid) stall_left--;
    end
  end

  // Monitor: feed accepted items to the model, check accepted results.
  always @(posedge clk) begin
    hacd_pkg::hacd_out_t want;
    hacd_pkg::hacd_out_t got;
    in_taken <= !rst && item_valid && !item_stall;
    out_taken <= !rst && result_valid && !result_stall;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        items_taken++;
        if (item.func == hacd_pkg::FUNC_END) scan_event();
        else accumulate_hit(item);
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (digit_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: valid=%0d module=%0d dur=%0d time=%0d count=%0d last=%0d",
                     got.digit_valid, got.digit_module, got.signal_duration,
                     got.earliest_time, got.fired_count, got.last);
          mismatches++;
        end else begin
          want = digit_q.pop_front();
          if (got.digit_valid !== want.digit_valid || got.digit_module !== want.digit_module ||
              got.signal_duration !== want.signal_duration ||
              got.earliest_time !== want.earliest_time ||
              got.fired_count !== want.fired_count || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("mismatch exp: valid=%0d module=%0d dur=%0d time=%0d count=%0d last=%0d",
                       want.digit_valid, want.digit_module, want.signal_duration,
                       want.earliest_time, want.fired_count, want.last);
              $display("         act: valid=%0d module=%0d dur=%0d time=%0d count=%0d last=%0d",
                       got.digit_valid, got.digit_module, got.signal_duration,
                       got.earliest_time, got.fired_count, got.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input bit wr, input logic [hacd_pkg::ADDR_W-1:0] a,
                            input logic [31:0] d, output logic [31:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (wr && a == THRESHOLD_ADDR) threshold_m = d[19:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes the threshold and reads it back.
  task automatic set_threshold(input logic [19:0] value);
    logic [31:0] rd;
    apb_access(1'b1, THRESHOLD_ADDR, {12'd0, value}, rd);
    apb_access(1'b0, THRESHOLD_ADDR, '0, rd);
    if (rd !== {12'd0, value}) begin
      $display("threshold readback: exp %0d act %0d", value, rd);
      reg_errors++;
    end
  endtask

  task automatic push_hit(input logic [7:0] copy, input logic signed [19:0] e,
                          input logic [19:0] t);
    hacd_pkg::hacd_in_t it;
    it.func = hacd_pkg::FUNC_HIT;
    it.module_copy = copy;
    it.energy_kev = e;
    it.hit_time = t;
    stim_q.push_back(it);
    items_total++;
    if (copy != 0 && copy <= NUM_MODULES) live_items++;
    last_time = t;
  endtask

  // End-of-event item; its other fields carry random junk.
  task automatic push_end();
    hacd_pkg::hacd_in_t it;
    it.func = hacd_pkg::FUNC_END;
    it.module_copy = 8'($urandom);
    it.energy_kev = 20'($urandom);
    it.hit_time = 20'($urandom);
    stim_q.push_back(it);
    items_total++;
    live_items++;
  endtask

  // Waits until every item is taken and every digit has arrived.
  task automatic wait_drained();
    while (items_taken != items_total || digit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [19:0] rand_energy();
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: return 20'(int'($urandom_range(0, 4000)) - 2000);
      2: return 20'($urandom_range(0, 60000));
      3: return 20'(int'(threshold_m) + int'($urandom_range(0, 200)) - 100);
      4: begin
        case ($urandom_range(0, 3))
          0: return 20'sh7FFFF;
          1: return 20'sh80000;
          2: return 20'sd0;
          default: return -20'sd1;
        endcase
      end
      default: return 20'($urandom_range(150, 1500));
    endcase
  endfunction

  function automatic logic [19:0] rand_time();
    return ($urandom_range(0, 3) == 0) ? last_time : 20'($urandom);
  endfunction

  function automatic logic [7:0] noise_copy();
    return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(NUM_MODULES + 1, 255));
  endfunction

  // One random event: mostly well-formed, with pile-ups, empty and
  // unterminated events mixed in.
  task automatic queue_random_event();
    int style;
    int n;
    int m;
    int base;
    bit up;
    style = $urandom_range(0, 9);
    case (style)
      0: push_end();
      1: begin
        // Pile-up on one module, driving the sum into saturation.
        m = $urandom_range(1, NUM_MODULES);
        up = $urandom_range(0, 1);
        n = $urandom_range(17, 20);
        for (int i = 0; i < n; i++)
          push_hit(8'(m), ($urandom_range(0, 4) == 0) ? rand_energy() :
                   (up ? 20'sh7FFFF : 20'sh80000), rand_time());
        push_end();
      end
      2: begin
        // Hits with no end marker; they carry into the next event.
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_hit(8'($urandom_range(1, NUM_MODULES)), rand_energy(), rand_time());
      end
      default: begin
        n = $urandom_range(1, 30);
        base = $urandom_range(1, NUM_MODULES - 3);
        up = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) m = noise_copy();
          else if (up) m = base + $urandom_range(0, 3);
          else m = $urandom_range(1, NUM_MODULES);
          push_hit(8'(m), rand_energy(), rand_time());
        end
        push_end();
      end
    endcase
  endtask

  // Main sequence: reset, directed events, then random phases.
  initial begin
    logic [19:0] thr_list [7];
    logic [31:0] rd;
    int target;
    for (int m = 0; m < NUM_MODULES; m++) begin
      hit_flag_m[m] = 1'b0;
      energy_sum_m[m] = 0;
      min_time_m[m] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The threshold must come out of reset at its default.
    apb_access(1'b0, THRESHOLD_ADDR, '0, rd);
    if (rd !== {12'd0, hacd_pkg::THRESHOLD_RST}) begin
      $display("threshold reset value: exp %0d act %0d", hacd_pkg::THRESHOLD_RST, rd);
      reg_errors++;
    end

    // Out-of-range copies, largest energies, equal times, threshold edge.
    push_hit(8'd0, 20'sd1000, 20'd10);
    push_hit(8'd41, 20'sd1000, 20'd10);
    push_hit(8'd255, 20'sh7FFFF, 20'hFFFFF);
    push_hit(8'd1, 20'sh7FFFF, 20'hFFFFF);
    push_hit(8'd1, 20'sh7FFFF, 20'h00123);
    push_hit(8'd1, 20'sd1000, 20'h00123);
    push_hit(8'd5, 20'sd400, 20'd7);
    push_hit(8'd6, 20'sd399, 20'd8);
    push_hit(8'd40, 20'sh80000, 20'd0);
    push_hit(8'd40, 20'sh7FFFF, 20'd3);
    push_end();
    push_end();
    wait_drained();

    // Duration clamps and interpolation edges, zero and negative sums.
    set_threshold(20'd0);
    push_hit(8'd2, 20'sd300, 20'd0);
    push_hit(8'd3, 20'sd301, 20'd1);
    push_hit(8'd4, 20'sd49999, 20'd2);
    push_hit(8'd8, 20'sd50000, 20'd3);
    push_hit(8'd9, 20'sd0, 20'd4);
    push_hit(8'd10, -20'sd1, 20'd5);
    push_hit(8'd11, 20'sd25000, 20'hFFFFF);
    push_end();
    wait_drained();

    // Random phases across several thresholds, the extremes among them.
    thr_list[0] = 20'hFFFFF;
    thr_list[1] = hacd_pkg::THRESHOLD_RST;
    thr_list[2] = 20'($urandom_range(0, 60000));
    thr_list[3] = 20'd1;
    thr_list[4] = 20'($urandom);
    thr_list[5] = 20'd0;
    thr_list[6] = 20'($urandom_range(200, 3000));
    for (int p = 0; p < 7; p++) begin
      set_threshold(thr_list[p]);
      calm = (p % 3 == 2);
      target = live_items + PHASE_ITEMS;
      while (live_items < target) queue_random_event();
      if (p == 6) push_end();
      wait_drained();
    end

    if (mismatches == 0 && reg_errors == 0) begin
      $display("module_hit_accumulator_digitizer_unit_tb passed");
    end else begin
      $display("module_hit_accumulator_digitizer_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/hacd_pkg.sv
hdl/hacd_ctrl.sv
hdl/hacd_datapath.sv
hdl/module_hit_accumulator_digitizer_unit.sv
test/module_hit_accumulator_digitizer_unit_tb.sv
